// ===== rtl/core/phtq_pkg.sv =====
// ---------------------------------------------------------------------------
// phtq_pkg
// Shared types and constants for the photon hit tally block.
// ---------------------------------------------------------------------------
package phtq_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int NUM_COUNTERS    = 9;

    localparam logic [24:0] WL_NUMERATOR = 25'd19837471;

    // process codes
    localparam logic [3:0] PROC_COMPT      = 4'd0;
    localparam logic [3:0] PROC_PHOT       = 4'd1;
    localparam logic [3:0] PROC_CERENKOV   = 4'd2;
    localparam logic [3:0] PROC_GREASE     = 4'd3;
    localparam logic [3:0] PROC_CRY_WIN    = 4'd4;
    localparam logic [3:0] PROC_GRS_WIN    = 4'd5;
    localparam logic [3:0] PROC_WIN_CATH   = 4'd6;
    localparam logic [3:0] PROC_CRY_CATH   = 4'd7;
    localparam logic [3:0] PROC_WIN_CRY    = 4'd8;
    localparam logic [3:0] PROC_GRS_CRY    = 4'd9;
    localparam logic [3:0] PROC_LAST_KNOWN = 4'd9;

    localparam logic [1:0] KIND_OTHER    = 2'd0;
    localparam logic [1:0] KIND_PHOTON   = 2'd1;
    localparam logic [1:0] KIND_ELECTRON = 2'd2;

    // counter slots
    localparam int C_CERENKOV  = 0;
    localparam int C_GREASE    = 1;
    localparam int C_WINDOW    = 2;
    localparam int C_WINDOW1   = 3;
    localparam int C_CATHODE   = 4;
    localparam int C_CATHODE1  = 5;
    localparam int C_DETECTED  = 6;
    localparam int C_DETECTED1 = 7;
    localparam int C_ELECTRON  = 8;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, start divider
        logic div_step;  // one restoring step
        logic seg_calc;  // register curve segment and product
        logic rcp_mul;   // reciprocal multiply for the segment fraction
        logic qe_calc;   // register efficiency
        logic commit;    // update state, form result
    } phtq_cmd_t;

    typedef struct packed {
        logic clear;
        logic unknown;
    } phtq_status_t;

endpackage

// ===== rtl/core/photon_hit_tally_with_qe.sv =====
// ---------------------------------------------------------------------------
// photon_hit_tally_with_qe
// Per-hit photon tallies with photocathode quantum-efficiency acceptance.
// ---------------------------------------------------------------------------
// One hit is taken at a time and yields one result beat. From acceptance a
// hit passes through the bit-serial restoring divider that turns energy into
// wavelength, then the efficiency curve steps (segment product, reciprocal
// multiply, scaling) and then commit. A clear or an unknown-process hit skips
// the divider and the curve and goes straight to commit. The result register
// holds a beat until taken, and commit waits until it is free; the next hit
// may be accepted the cycle after commit, so a new hit is not taken until the
// last one has been committed.
module photon_hit_tally_with_qe #(
    parameter int COUNT_WIDTH = phtq_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = phtq_pkg::TIME_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         qe_model_we,
    input  logic         qe_model_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // particle_kind, process_code, energy_mev, tube_index, hit_time, uniform_draw
    input  logic [71:0]  s_tdata,
    // clear_event
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted, unknown_process, cerenkov_count, grease_count, window_count,
    // window_tube_one_count, cathode_count, cathode_tube_one_count,
    // detected_count, detected_tube_one_count, electron_count, earliest_time
    output logic [327:0] m_tdata
);
    import phtq_pkg::*;

    logic         qe_model_reg;
    phtq_cmd_t    cmd;
    phtq_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn)         qe_model_reg <= 1'b0;
        else if (qe_model_we) qe_model_reg <= qe_model_wdata;
    end

    phtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    phtq_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qe_model (qe_model_reg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/phtq_ctrl.sv =====
// ---------------------------------------------------------------------------
// phtq_ctrl
// Sequencer: accept, 25 divider steps, three curve steps, commit, output hold.
// ---------------------------------------------------------------------------
module phtq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  phtq_pkg::phtq_status_t status,
    output phtq_pkg::phtq_cmd_t   cmd
);
    import phtq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SEG  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_QE   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;

    // result register frees once taken or taken this cycle
    logic out_free;
    assign out_free = !ovalid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg && !m_tready;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = 5'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.clear || status.unknown) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd24) state_next = ST_SEG;
                end
            end
            ST_SEG: begin
                cmd.seg_calc = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.rcp_mul = 1'b1;
                state_next  = ST_QE;
            end
            ST_QE: begin
                cmd.qe_calc = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.commit  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 5'd0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== rtl/core/phtq_datapath.sv =====
// ---------------------------------------------------------------------------
// phtq_datapath
// Item capture, restoring divider, efficiency curves, tallies and result.
// ---------------------------------------------------------------------------
module phtq_datapath #(
    parameter int COUNT_WIDTH = phtq_pkg::COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = phtq_pkg::TIME_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   qe_model,
    input  logic [71:0]            s_tdata,
    input  logic                   s_tuser,
    input  phtq_pkg::phtq_cmd_t    cmd,
    output phtq_pkg::phtq_status_t status,
    output logic [327:0]           m_tdata
);
    import phtq_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // ceil(2^26 / odd part of the segment span)
    localparam logic [23:0] RCP_5  = 24'd13421773;
    localparam logic [23:0] RCP_15 = 24'd4473925;
    localparam logic [23:0] RCP_25 = 24'd2684355;
    localparam logic [23:0] RCP_35 = 24'd1917397;
    localparam logic [23:0] RCP_55 = 24'd1220162;

    // captured item
    logic                  clr_reg;
    logic [1:0]            kind_reg;
    logic [3:0]            proc_reg;
    logic [15:0]           energy_reg;
    logic                  tube1_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [15:0]           draw_reg;

    // divider: 25-bit dividend shifted out, 17-bit partial remainder
    logic [24:0] quo_reg;
    logic [16:0] rem_reg;
    logic [16:0] rem_sh;
    logic [17:0] rem_try;

    logic [15:0] qe_reg;

    logic [COUNT_WIDTH-1:0] cnt_reg [NUM_COUNTERS];
    logic                   first_valid_reg;
    logic [TIME_WIDTH-1:0]  first_time_reg;

    logic accepted_reg, unknown_reg;

    assign status.clear   = clr_reg;
    assign status.unknown = (proc_reg > PROC_LAST_KNOWN);

    assign rem_sh  = {rem_reg[15:0], quo_reg[24]};
    assign rem_try = {1'b0, rem_sh} - {2'b00, energy_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            clr_reg    <= s_tuser;
            kind_reg   <= s_tdata[1:0];
            proc_reg   <= s_tdata[5:2];
            energy_reg <= s_tdata[21:6];
            tube1_reg  <= (s_tdata[23:22] == 2'd1);
            time_reg   <= TIME_WIDTH'(s_tdata[55:24]);
            draw_reg   <= s_tdata[71:56];
            quo_reg    <= WL_NUMERATOR;
            rem_reg    <= '0;
        end else if (cmd.div_step) begin
            if (!rem_try[17]) begin
                rem_reg <= rem_try[16:0];
                quo_reg <= {quo_reg[23:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[23:0], 1'b0};
            end
        end
    end

    // wavelength in 1/16 nm; zero energy treated as infinite
    logic        inf;
    logic [24:0] wl;
    assign inf = (energy_reg == 16'd0);
    assign wl  = quo_reg;

    // one curve segment: start point, end point in nm, slope computed once
    logic [15:0] x1, x2;
    logic [15:0] y1, y2;
    logic        flat;
    logic [15:0] flat_q;
    logic        zero_q;
    logic        std_sel;

    always_comb begin
        x1 = 16'd0; x2 = 16'd1; y1 = 16'd0; y2 = 16'd0;
        flat = 1'b0; flat_q = 16'd0; zero_q = 1'b0;
        std_sel = !qe_model;
        if (!qe_model) begin
            priority if (inf || wl >= 25'(750*16)) zero_q = 1'b1;
            else if (wl < 25'(330*16)) begin flat = 1'b1; flat_q = 16'd14418; end
            else if (wl < 25'(400*16)) begin
                x1 = 16'd330; y1 = 16'd14418; x2 = 16'd400; y2 = 16'd16384;
            end else if (wl < 25'(430*16)) begin
                x1 = 16'd400; y1 = 16'd16384; x2 = 16'd430; y2 = 16'd15073;
            end else if (wl < 25'(530*16)) begin
                x1 = 16'd430; y1 = 16'd15073; x2 = 16'd530; y2 = 16'd7864;
            end else begin
                x1 = 16'd530; y1 = 16'd7864; x2 = 16'd750; y2 = 16'd0;
            end
        end else begin
            priority if (inf || wl < 25'(200*16) || wl >= 25'(650*16)) zero_q = 1'b1;
            else if (wl < 25'(340*16)) begin flat = 1'b1; flat_q = 16'd13763; end
            else if (wl < 25'(380*16)) begin
                x1 = 16'd340; y1 = 16'd13763; x2 = 16'd380; y2 = 16'd14418;
            end else if (wl < 25'(500*16)) begin
                x1 = 16'd380; y1 = 16'd13763; x2 = 16'd500; y2 = 16'd7209;
            end else if (wl < 25'(540*16)) begin
                x1 = 16'd500; y1 = 16'd7209; x2 = 16'd540; y2 = 16'd2621;
            end else begin
                x1 = 16'd540; y1 = 16'd2621; x2 = 16'd650; y2 = 16'd0;
            end
        end
    end

    // rounded product for the segment, span is at most 3520
    logic [15:0] span, dx, dy;
    logic        up;
    logic [31:0] prod;
    assign span = (x2 - x1) << 4;
    assign dx   = 16'(wl) - (x1 << 4);
    assign up   = (y2 >= y1);
    assign dy   = up ? (y2 - y1) : (y1 - y2);
    assign prod = dy * dx + {17'd0, span[15:1]};

    // span = 2^k * odd: shift out 2^k, then multiply by the odd reciprocal,
    // exact for the shifted product below 2^20
    logic [19:0] num_sel;
    logic [23:0] rcp_sel;
    always_comb begin
        unique case (span)
            16'd1120: begin num_sel = 20'(prod >> 5); rcp_sel = RCP_35; end
            16'd480:  begin num_sel = 20'(prod >> 5); rcp_sel = RCP_15; end
            16'd1600: begin num_sel = 20'(prod >> 6); rcp_sel = RCP_25; end
            16'd3520: begin num_sel = 20'(prod >> 6); rcp_sel = RCP_55; end
            16'd640:  begin num_sel = 20'(prod >> 7); rcp_sel = RCP_5;  end
            16'd1920: begin num_sel = 20'(prod >> 7); rcp_sel = RCP_15; end
            16'd1760: begin num_sel = 20'(prod >> 5); rcp_sel = RCP_55; end
            default:  begin num_sel = 20'd0;          rcp_sel = 24'd0;  end
        endcase
    end

    logic [19:0] num_reg;
    logic [23:0] rcp_reg;
    logic        flat_reg, zero_reg, std_reg, up_reg;
    logic [15:0] flat_q_reg, y1_reg;
    logic [43:0] rcp_prod;
    logic [15:0] frac_reg;

    always_ff @(posedge aclk) begin
        if (cmd.seg_calc) begin
            num_reg    <= num_sel;
            rcp_reg    <= rcp_sel;
            flat_reg   <= flat;
            flat_q_reg <= flat_q;
            zero_reg   <= zero_q;
            std_reg    <= std_sel;
            up_reg     <= up;
            y1_reg     <= y1;
        end
    end

    assign rcp_prod = num_reg * rcp_reg;

    always_ff @(posedge aclk) begin
        if (cmd.rcp_mul) frac_reg <= rcp_prod[41:26];
    end

    logic [15:0] q_raw;
    logic [31:0] q_scaled;
    assign q_raw    = flat_reg ? flat_q_reg : (up_reg ? (y1_reg + frac_reg) : (y1_reg - frac_reg));
    assign q_scaled = q_raw * 32'd39322 + 32'd32768;

    always_ff @(posedge aclk) begin
        if (cmd.qe_calc) begin
            if (zero_reg)     qe_reg <= 16'd0;
            else if (std_reg) qe_reg <= q_scaled[31:16];
            else              qe_reg <= q_raw;
        end
    end

    // tallies
    logic inband, cathode, pass;
    logic [NUM_COUNTERS-1:0] bump;
    assign inband  = (kind_reg == KIND_PHOTON) && !inf &&
                     (wl > 25'(200*16)) && (wl < 25'(800*16));
    assign cathode = (proc_reg == PROC_WIN_CATH) || (proc_reg == PROC_CRY_CATH);
    // zero energy forces the efficiency to zero, so only a zero draw passes
    assign pass    = cathode && (draw_reg <= qe_reg);

    always_comb begin
        bump = '0;
        bump[C_CERENKOV]  = inband && (proc_reg == PROC_CERENKOV);
        bump[C_GREASE]    = inband && (proc_reg == PROC_GREASE);
        bump[C_WINDOW]    = inband && ((proc_reg == PROC_CRY_WIN) ||
                                       (proc_reg == PROC_GRS_WIN));
        bump[C_WINDOW1]   = bump[C_WINDOW] && tube1_reg;
        bump[C_CATHODE]   = inband && cathode;
        bump[C_CATHODE1]  = bump[C_CATHODE] && tube1_reg;
        bump[C_DETECTED]  = pass;
        bump[C_DETECTED1] = pass && tube1_reg;
        bump[C_ELECTRON]  = (kind_reg == KIND_ELECTRON);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COUNTERS; i++) cnt_reg[i] <= '0;
            first_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            if (clr_reg) begin
                for (int i = 0; i < NUM_COUNTERS; i++) cnt_reg[i] <= '0;
                first_valid_reg <= 1'b0;
            end else if (!status.unknown) begin
                for (int i = 0; i < NUM_COUNTERS; i++)
                    if (bump[i] && cnt_reg[i] != CNT_MAX) cnt_reg[i] <= cnt_reg[i] + 1'b1;
                if (pass && (!first_valid_reg || time_reg < first_time_reg))
                    first_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && !clr_reg && !status.unknown && pass &&
            (!first_valid_reg || time_reg < first_time_reg))
            first_time_reg <= time_reg;
        if (cmd.commit) begin
            accepted_reg <= !clr_reg && !status.unknown && pass;
            unknown_reg  <= !clr_reg && status.unknown;
        end
    end

    // counters shown as 32 bits, zero-extended or truncated
    always_comb begin
        m_tdata[0] = accepted_reg;
        m_tdata[1] = unknown_reg;
        for (int i = 0; i < NUM_COUNTERS; i++)
            m_tdata[2 + 32*i +: 32] = 32'(cnt_reg[i]);
        m_tdata[290 +: 33] = first_valid_reg ? 33'(first_time_reg) : '1;
        m_tdata[327:323] = 5'd0;
    end

endmodule
